// ===== sv/rbst_pkg.sv =====
// ---------------------------------------------------------------------------
// rbst_pkg
// Shared widths and constants for the ray versus box slab test.
// ---------------------------------------------------------------------------
`default_nettype none
package rbst_pkg;
  localparam int unsigned Q_W        = 32;  // Q16.16 value
  localparam int unsigned DIST_W     = 33;  // plane distance, Q17.16
  localparam int unsigned FRAC_W     = 16;
  localparam int unsigned AXES       = 3;
  localparam int unsigned STEP_BITS  = 4;   // quotient bits per divider stage
  localparam int unsigned DIV_STEPS  = Q_W / STEP_BITS;
  localparam int unsigned DIV_LAT    = DIV_STEPS + 3;
  localparam logic signed [Q_W-1:0] Q_MAX = {1'b0, {(Q_W-1){1'b1}}};
  localparam logic signed [Q_W-1:0] Q_MIN = {1'b1, {(Q_W-1){1'b0}}};
endpackage
`default_nettype wire

// ===== sv/ray_box_slab_test.sv =====
// ---------------------------------------------------------------------------
// ray_box_slab_test
// Ray against axis-aligned box slab test in signed Q16.16.
// ---------------------------------------------------------------------------
// One ray/box beat is taken every cycle (busy is always low). Each beat gives
// one hit strobe on out_valid after the input registers, the six pipelined
// dividers, which produce four quotient bits per stage, and the reduction and
// decision registers. The receiver cannot stall, and none is needed.
`default_nettype none
module ray_box_slab_test (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic signed [31:0] in_origin_x,
  input  wire logic signed [31:0] in_origin_y,
  input  wire logic signed [31:0] in_origin_z,
  input  wire logic signed [31:0] in_direction_x,
  input  wire logic signed [31:0] in_direction_y,
  input  wire logic signed [31:0] in_direction_z,
  input  wire logic signed [31:0] in_box_low_x,
  input  wire logic signed [31:0] in_box_low_y,
  input  wire logic signed [31:0] in_box_low_z,
  input  wire logic signed [31:0] in_box_high_x,
  input  wire logic signed [31:0] in_box_high_y,
  input  wire logic signed [31:0] in_box_high_z,
  output logic             out_valid,
  output logic             out_hit
);
  localparam int unsigned QW = rbst_pkg::Q_W;
  localparam int unsigned DW = rbst_pkg::DIST_W;
  localparam int unsigned NA = rbst_pkg::AXES;
  localparam int unsigned LAT = rbst_pkg::DIV_LAT;

  assign busy = 1'b0;

  logic signed [QW-1:0] o_w [NA], d_w [NA], lo_w [NA], hi_w [NA];
  assign o_w  = '{in_origin_x, in_origin_y, in_origin_z};
  assign d_w  = '{in_direction_x, in_direction_y, in_direction_z};
  assign lo_w = '{in_box_low_x, in_box_low_y, in_box_low_z};
  assign hi_w = '{in_box_high_x, in_box_high_y, in_box_high_z};

  // plane distances and zero-direction checks
  logic signed [DW-1:0] near_r [NA], far_r [NA];
  logic signed [QW-1:0] dir_r [NA];
  logic [NA-1:0] zero_r, out_r;
  logic          v1_r;

  always_ff @(posedge clk) begin
    logic signed [DW-1:0] o_e, lo_e, hi_e;
    for (int a = 0; a < NA; a++) begin
      o_e  = DW'(o_w[a]);
      lo_e = DW'(lo_w[a]);
      hi_e = DW'(hi_w[a]);
      near_r[a] <= d_w[a][QW-1] ? hi_e - o_e : lo_e - o_e;
      far_r[a]  <= d_w[a][QW-1] ? lo_e - o_e : hi_e - o_e;
      dir_r[a]  <= d_w[a];
      zero_r[a] <= (d_w[a] == '0);
      out_r[a]  <= (o_w[a] < lo_w[a]) || (o_w[a] > hi_w[a]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v1_r <= 1'b0;
    else        v1_r <= start;
  end

  // dividers
  logic signed [QW-1:0] tn_w [NA], tf_w [NA];
  for (genvar a = 0; a < NA; a++) begin : g_div
    rbst_div u_near (.clk(clk), .span(near_r[a]), .dir(dir_r[a]), .quot(tn_w[a]));
    rbst_div u_far  (.clk(clk), .span(far_r[a]),  .dir(dir_r[a]), .quot(tf_w[a]));
  end

  // side-band delay line matching the divider latency
  logic          vd_r [LAT];
  logic [NA-1:0] zd_r [LAT];
  logic          md_r [LAT];
  always_ff @(posedge clk) begin
    zd_r[0] <= zero_r;
    md_r[0] <= |(zero_r & out_r);
    for (int i = 1; i < LAT; i++) begin
      zd_r[i] <= zd_r[i-1];
      md_r[i] <= md_r[i-1];
    end
  end
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < LAT; i++) vd_r[i] <= 1'b0;
    end else begin
      vd_r[0] <= v1_r;
      for (int i = 1; i < LAT; i++) vd_r[i] <= vd_r[i-1];
    end
  end

  // entry and exit reduction
  logic signed [QW-1:0] entry_r, exit_r;
  logic                 miss_r, v2_r;
  always_ff @(posedge clk) begin
    logic signed [QW-1:0] en_v, ex_v;
    en_v = '0;
    ex_v = rbst_pkg::Q_MAX;
    for (int a = 0; a < NA; a++) begin
      if (!zd_r[LAT-1][a]) begin
        if (tn_w[a] > en_v) en_v = tn_w[a];
        if (tf_w[a] < ex_v) ex_v = tf_w[a];
      end
    end
    entry_r <= en_v;
    exit_r  <= ex_v;
    miss_r  <= md_r[LAT-1];
  end

  // hit decision and result beat
  logic hit_r, ov_r;
  always_ff @(posedge clk) begin
    hit_r <= !miss_r && (entry_r < exit_r);
  end
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
      ov_r <= 1'b0;
    end else begin
      v2_r <= vd_r[LAT-1];
      ov_r <= v2_r;
    end
  end

  assign out_valid = ov_r;
  assign out_hit   = hit_r;
endmodule
`default_nettype wire

// ===== sv/rbst_div.sv =====
// ---------------------------------------------------------------------------
// rbst_div
// Pipelined saturating signed divide: (span * 2^16) / dir, truncated toward
// zero and clamped to Q16.16. Fixed latency, one beat per cycle.
// ---------------------------------------------------------------------------
`default_nettype none
module rbst_div (
  input  wire logic                             clk,
  input  wire logic signed [rbst_pkg::DIST_W-1:0] span,
  input  wire logic signed [rbst_pkg::Q_W-1:0]    dir,
  output logic signed [rbst_pkg::Q_W-1:0]         quot
);
  localparam int unsigned QW = rbst_pkg::Q_W;
  localparam int unsigned DW = rbst_pkg::DIST_W;
  localparam int unsigned FW = rbst_pkg::FRAC_W;
  localparam int unsigned NS = rbst_pkg::DIV_STEPS;
  localparam int unsigned SB = rbst_pkg::STEP_BITS;

  // magnitudes and result sign
  logic [DW-1:0] n_mag_r;
  logic [QW-1:0] d_mag_r;
  logic          neg_a_r;

  always_ff @(posedge clk) begin
    n_mag_r <= span[DW-1] ? DW'(-span) : DW'(span);
    d_mag_r <= dir[QW-1] ? QW'(-dir) : QW'(dir);
    neg_a_r <= span[DW-1] ^ dir[QW-1];
  end

  // overflow check and initial partial remainder
  logic [QW-1:0] rem_r [NS+1];
  logic [QW-1:0] num_r [NS+1];
  logic [QW-1:0] q_r   [NS+1];
  logic [QW-1:0] d_r   [NS+1];
  logic          neg_r [NS+1];
  logic          big_r [NS+1];

  always_ff @(posedge clk) begin
    big_r[0] <= {{(QW+FW-DW){1'b0}}, n_mag_r} >= {d_mag_r, {FW{1'b0}}};
    rem_r[0] <= QW'(n_mag_r[DW-1:FW]);
    num_r[0] <= {n_mag_r[FW-1:0], {(QW-FW){1'b0}}};
    q_r[0]   <= '0;
    d_r[0]   <= d_mag_r;
    neg_r[0] <= neg_a_r;
  end

  // restoring division, a few quotient bits per stage
  for (genvar s = 0; s < NS; s++) begin : g_step
    logic [QW-1:0] rem_nxt, num_nxt, q_nxt;
    always_comb begin
      logic [QW:0] r_w;
      rem_nxt = rem_r[s];
      num_nxt = num_r[s];
      q_nxt   = q_r[s];
      for (int b = 0; b < SB; b++) begin
        r_w     = {rem_nxt, num_nxt[QW-1]};
        num_nxt = {num_nxt[QW-2:0], 1'b0};
        if (r_w >= {1'b0, d_r[s]}) begin
          r_w   = r_w - {1'b0, d_r[s]};
          q_nxt = {q_nxt[QW-2:0], 1'b1};
        end else begin
          q_nxt = {q_nxt[QW-2:0], 1'b0};
        end
        rem_nxt = r_w[QW-1:0];
      end
    end
    always_ff @(posedge clk) begin
      rem_r[s+1] <= rem_nxt;
      num_r[s+1] <= num_nxt;
      q_r[s+1]   <= q_nxt;
      d_r[s+1]   <= d_r[s];
      neg_r[s+1] <= neg_r[s];
      big_r[s+1] <= big_r[s];
    end
  end

  // sign and saturation
  logic signed [QW-1:0] quot_r;
  always_ff @(posedge clk) begin
    if (neg_r[NS]) begin
      if (big_r[NS] || (q_r[NS] > QW'(rbst_pkg::Q_MIN))) quot_r <= rbst_pkg::Q_MIN;
      else quot_r <= QW'(-q_r[NS]);
    end else begin
      if (big_r[NS] || q_r[NS][QW-1]) quot_r <= rbst_pkg::Q_MAX;
      else quot_r <= q_r[NS];
    end
  end

  assign quot = quot_r;
endmodule
`default_nettype wire
